/* rtl/core/subarray_sum_equals_k_counter_defines.svh */
// assertion macros for the subarray sum counter rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef SUBARRAY_SUM_EQUALS_K_COUNTER_DEFINES_SVH
`define SUBARRAY_SUM_EQUALS_K_COUNTER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SSEK_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssek assertion failed");
// next-cycle implication
`define SSEK_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssek assertion failed");
`else
`define SSEK_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SSEK_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/ssek_pkg.sv */
// constants, types and helpers for the subarray sum counter
// no dependencies; imported by every other rtl file but the assertion macro header
`timescale 1ns / 1ps

package ssek_pkg;

    localparam int MAX_LEN      = 256;
    localparam int ELEMENT_BITS = 16;
    localparam int PREFIX_BITS  = 25;
    localparam int TOTAL_BITS   = 16;
    localparam int IDX_BITS     = $clog2(MAX_LEN);
    localparam int CNT_BITS     = $clog2(MAX_LEN + 1);

    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

    // word travelling down the cell chain
    typedef struct packed {
        logic                   valid;
        logic                   last;
        logic                   ovf;
        logic [CNT_BITS-1:0]    slot;
        logic [CNT_BITS-1:0]    hits;
        logic [PREFIX_BITS-1:0] wanted;
        logic [PREFIX_BITS-1:0] prefix;
    } t_stage;

    function automatic logic [PREFIX_BITS-1:0] sext_elem(
        input logic signed [ELEMENT_BITS-1:0] elem
    );
        logic signed [PREFIX_BITS-1:0] wide;
        wide = PREFIX_BITS'(elem);
        return wide;
    endfunction

endpackage

/* rtl/core/ssek_ifs.sv */
// valid/ready channel interfaces: element input, result output, target write
// depends on ssek_pkg
`timescale 1ns / 1ps

interface ssek_in_if import ssek_pkg::*;;
    logic                           valid;
    logic                           ready;
    logic signed [ELEMENT_BITS-1:0] element_value;
    logic                           last_element;

    modport source (output valid, element_value, last_element, input ready);
    modport sink   (input valid, element_value, last_element, output ready);
endinterface

interface ssek_out_if import ssek_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [TOTAL_BITS-1:0] match_count;
    logic                  length_overflow;
    logic                  array_done;

    modport source (output valid, match_count, length_overflow, array_done, input ready);
    modport sink   (input valid, match_count, length_overflow, array_done, output ready);
endinterface

interface ssek_cfg_if import ssek_pkg::*;;
    logic                          valid;
    logic                          ready;
    logic signed [PREFIX_BITS-1:0] target_sum;

    modport source (output valid, target_sum, input ready);
    modport sink   (input valid, target_sum, output ready);
endinterface

/* rtl/core/ssek_cell.sv */
// one cell of the prefix chain: holds one stored prefix and one stage register
// depends on ssek_pkg
`timescale 1ns / 1ps

module ssek_cell import ssek_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic [IDX_BITS-1:0] i_index,
    input  t_stage              i_stage,
    output t_stage              o_stage
);

    logic [PREFIX_BITS-1:0] r_entry;
    t_stage                 r_stage;
    t_stage                 n_stage;
    logic                   w_hit;
    logic                   w_mine;

    // entry is live only for words whose array already wrote it
    assign w_hit  = i_stage.valid && (CNT_BITS'(i_index) < i_stage.slot)
                    && (r_entry == i_stage.wanted);
    assign w_mine = i_stage.valid && (i_stage.slot == CNT_BITS'(i_index));

    always_comb begin
        n_stage      = i_stage;
        n_stage.hits = i_stage.hits + CNT_BITS'(w_hit);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && w_mine) begin
            r_entry <= i_stage.prefix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_adv) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

/* rtl/core/ssek_front.sv */
// chain entry: running prefix, fill count, target register, implicit zero match
// depends on ssek_pkg and ssek_ifs
`timescale 1ns / 1ps

module ssek_front import ssek_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    ssek_in_if.sink    i_in,
    ssek_cfg_if.sink   i_cfg,
    output t_stage     o_stage
);

    logic [PREFIX_BITS-1:0] r_target;
    logic [PREFIX_BITS-1:0] r_prefix;
    logic [PREFIX_BITS-1:0] r_wanted;
    logic [CNT_BITS-1:0]    r_held;
    logic [PREFIX_BITS-1:0] n_prefix;
    logic [PREFIX_BITS-1:0] n_wanted;
    logic [PREFIX_BITS-1:0] w_elem;
    logic                   w_accept;
    logic                   w_full;

    // a target write takes the cycle; no element is taken alongside it
    assign i_in.ready  = i_adv && i_rst_n && !i_cfg.valid;
    assign i_cfg.ready = i_rst_n;
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_full      = (r_held == CNT_BITS'(MAX_LEN));

    // prefix and prefix minus target are kept side by side
    assign w_elem   = sext_elem(i_in.element_value);
    assign n_prefix = r_prefix + w_elem;
    assign n_wanted = r_wanted + w_elem;

    always_comb begin
        o_stage.valid  = w_accept;
        o_stage.last   = i_in.last_element;
        o_stage.ovf    = w_full;
        o_stage.slot   = r_held;
        o_stage.hits   = CNT_BITS'(n_wanted == '0);
        o_stage.wanted = n_wanted;
        o_stage.prefix = n_prefix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
            r_prefix <= '0;
            r_wanted <= '0;
            r_held   <= '0;
        end else if (i_cfg.valid) begin
            r_target <= i_cfg.target_sum;
            r_wanted <= r_prefix - i_cfg.target_sum;
        end else if (w_accept) begin
            if (i_in.last_element) begin
                r_prefix <= '0;
                r_wanted <= '0 - r_target;
                r_held   <= '0;
            end else begin
                r_prefix <= n_prefix;
                r_wanted <= n_wanted;
                if (!w_full) begin
                    r_held <= r_held + 1'b1;
                end
            end
        end
    end

endmodule

/* rtl/core/ssek_tail.sv */
// chain exit: saturating running total, sticky overflow, output register
// depends on ssek_pkg, ssek_ifs and the assertion macro header
`timescale 1ns / 1ps
`include "subarray_sum_equals_k_counter_defines.svh"

module ssek_tail import ssek_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_stage     i_stage,
    output logic       o_adv,
    ssek_out_if.source o_out
);

    logic [TOTAL_BITS-1:0] r_total;
    logic                  r_ovf_seen;
    logic                  r_out_valid;
    logic [TOTAL_BITS-1:0] r_count;
    logic                  r_ovf;
    logic                  r_done;
    logic [TOTAL_BITS:0]   w_sum;
    logic [TOTAL_BITS-1:0] n_total;
    logic                  n_ovf;

    assign o_adv   = !r_out_valid || o_out.ready;
    assign w_sum   = {1'b0, r_total} + (TOTAL_BITS + 1)'(i_stage.hits);
    assign n_total = w_sum[TOTAL_BITS] ? TOTAL_MAX : w_sum[TOTAL_BITS-1:0];
    assign n_ovf   = r_ovf_seen || i_stage.ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_ovf_seen  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (o_adv) begin
            r_out_valid <= i_stage.valid;
            if (i_stage.valid) begin
                if (i_stage.last) begin
                    r_total    <= '0;
                    r_ovf_seen <= 1'b0;
                end else begin
                    r_total    <= n_total;
                    r_ovf_seen <= n_ovf;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_stage.valid) begin
            r_count <= n_total;
            r_ovf   <= n_ovf;
            r_done  <= i_stage.last;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.match_count     = r_count;
    assign o_out.length_overflow = r_ovf;
    assign o_out.array_done      = r_done;

    `SSEK_ASSERT_IMP(a_hits_bound, i_clk, i_rst_n, i_stage.valid, i_stage.hits <= i_stage.slot + 1'b1)
    `SSEK_ASSERT_IMP(a_ovf_full, i_clk, i_rst_n, i_stage.valid && i_stage.ovf, i_stage.slot == CNT_BITS'(MAX_LEN))
    `SSEK_ASSERT_NXT(a_last_clears, i_clk, i_rst_n, o_adv && i_stage.valid && i_stage.last, r_total == '0 && !r_ovf_seen)
    `SSEK_ASSERT_NXT(a_total_grows, i_clk, i_rst_n, o_adv && i_stage.valid && !i_stage.last, r_total >= $past(r_total))

endmodule

/* rtl/core/subarray_sum_equals_k_counter.sv */
// an accepted word passes each cell's stage register, then the tail's output register
// throughput: one word per cycle; stalls only while a result is held or a target is written
// every earlier prefix lives in its own cell; queries ripple one cell per cycle while the chain advances
// reset (synchronous, active low) clears target, prefix, fill count, total, flag, valid bits
// stored prefixes are not cleared; a cell is only compared once its array wrote it
`timescale 1ns / 1ps

module subarray_sum_equals_k_counter import ssek_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ssek_in_if.sink    i_in,
    ssek_cfg_if.sink   i_cfg,
    ssek_out_if.source o_out
);

    // stage words between neighbouring cells; index 0 is the front's output
    t_stage w_chain [MAX_LEN+1];
    // common advance for the whole chain, so write/read ordering between words holds
    logic   w_adv;

    // front: accumulates the prefix, counts the implicit zero prefix, assigns the slot
    ssek_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .o_stage (w_chain[0])
    );

    // cell g stores the prefix of element g and compares every later word against it
    for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
        ssek_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_index (IDX_BITS'(g)),
            .i_stage (w_chain[g]),
            .o_stage (w_chain[g+1])
        );
    end

    // tail: folds per-word hits into the saturating total and holds the result word
    ssek_tail u_tail (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (w_chain[MAX_LEN]),
        .o_adv   (w_adv),
        .o_out   (o_out)
    );

endmodule
